[rtl/core/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, ignored while reset is high
`define BPLB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bplb assertion failed");

// checked property, also during reset
`define BPLB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bplb assertion failed");

`endif

[rtl/core/bplb_pkg.sv]
// shared constants for the button press classifier and led blinker
`default_nettype none

package bplb_pkg;

  localparam int unsigned TIMER_WIDTH_DEFAULT = 16;
  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BLINK_BASE = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd5;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd200;
  localparam logic [CFG_WIDTH-1:0] BLINK_BASE_RESET = 16'd100;

  // button state codes
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_DEBOUNCING = 3'd1;
  localparam logic [2:0] ST_PRESSED    = 3'd2;
  localparam logic [2:0] ST_HELD       = 3'd3;
  localparam logic [2:0] ST_DOWN       = 3'd4;
  localparam logic [2:0] ST_RELEASED   = 3'd5;

  // led mode codes
  localparam logic [2:0] LED_OFF        = 3'd0;
  localparam logic [2:0] LED_MODE_FIRST = 3'd1;
  localparam logic [2:0] LED_MODE_LAST  = 3'd4;

endpackage

`default_nettype wire

[rtl/core/bplb_press.sv]
// press classification state machine with debounce and long-press timer
`default_nettype none

module bplb_press #(
  parameter int unsigned TIMER_WIDTH = bplb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic                   level,
  input  wire logic [TIMER_WIDTH-1:0] debounce_max,
  input  wire logic [TIMER_WIDTH-1:0] long_max,
  output logic      [2:0]             state_now,
  output logic      [2:0]             state_next
);

  typedef enum logic [2:0] {
    S_IDLE       = bplb_pkg::ST_IDLE,
    S_DEBOUNCING = bplb_pkg::ST_DEBOUNCING,
    S_PRESSED    = bplb_pkg::ST_PRESSED,
    S_HELD       = bplb_pkg::ST_HELD,
    S_DOWN       = bplb_pkg::ST_DOWN,
    S_RELEASED   = bplb_pkg::ST_RELEASED
  } press_state_t;

  press_state_t           state;
  press_state_t           press_state_next;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  logic [TIMER_WIDTH-1:0] timer_inc;

  always_comb begin
    press_state_next = state;
    timer_next       = timer;
    timer_inc        = timer + TIMER_WIDTH'(1);
    case (state)
      S_DEBOUNCING: begin
        // blind wait, level ignored
        timer_next = timer_inc;
        if (timer_inc >= debounce_max) begin
          press_state_next = S_PRESSED;
          timer_next       = '0;
        end
      end
      S_PRESSED, S_DOWN: begin
        if (!level) begin
          press_state_next = (state == S_PRESSED) ? S_RELEASED : S_IDLE;
        end else if (timer >= long_max) begin
          press_state_next = S_HELD;
        end else begin
          timer_next = timer_inc;
        end
      end
      S_HELD: begin
        if (!level) begin
          press_state_next = S_IDLE;
        end else begin
          press_state_next = S_DOWN;
          timer_next       = '0;
        end
      end
      S_RELEASED: begin
        press_state_next = S_IDLE;
      end
      default: begin
        if (level) begin
          press_state_next = S_DEBOUNCING;
          timer_next       = '0;
        end else begin
          press_state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      timer <= '0;
    end else if (step) begin
      state <= press_state_next;
      timer <= timer_next;
    end
  end

  assign state_now  = state;
  assign state_next = press_state_next;

endmodule

`default_nettype wire

[rtl/core/bplb_blink.sv]
// led mode selection and blink half-period timer
`default_nettype none

module bplb_blink #(
  parameter int unsigned TIMER_WIDTH = bplb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [2:0]             press_next,
  input  wire logic [TIMER_WIDTH-1:0] base_max,
  output logic      [2:0]             mode_now,
  output logic                        lit
);

  logic [2:0]             mode;
  logic [2:0]             mode_next;
  logic [TIMER_WIDTH-1:0] timer;
  logic [TIMER_WIDTH-1:0] timer_next;
  logic [TIMER_WIDTH-1:0] timer_inc;
  logic [TIMER_WIDTH-1:0] half;
  logic                   phase;
  logic                   phase_next;

  always_comb begin
    mode_next = mode;
    if (press_next == bplb_pkg::ST_HELD) begin
      mode_next = (mode == bplb_pkg::LED_OFF) ? bplb_pkg::LED_MODE_FIRST : bplb_pkg::LED_OFF;
    end else if (press_next == bplb_pkg::ST_RELEASED && mode != bplb_pkg::LED_OFF) begin
      mode_next = (mode >= bplb_pkg::LED_MODE_LAST) ? bplb_pkg::LED_MODE_FIRST
                                                    : mode + 3'd1;
    end

    timer_inc  = timer + TIMER_WIDTH'(1);
    half       = base_max >> 2'(mode_next - bplb_pkg::LED_MODE_FIRST);
    timer_next = timer;
    phase_next = phase;
    if (mode_next == bplb_pkg::LED_OFF || mode_next > bplb_pkg::LED_MODE_LAST) begin
      // off: timer holds, led dark
      mode_next  = bplb_pkg::LED_OFF;
      phase_next = 1'b0;
    end else if (timer_inc >= half) begin
      phase_next = ~phase;
      timer_next = '0;
    end else begin
      timer_next = timer_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= bplb_pkg::LED_OFF;
      timer <= '0;
      phase <= 1'b0;
    end else if (step) begin
      mode  <= mode_next;
      timer <= timer_next;
      phase <= phase_next;
    end
  end

  assign mode_now = mode;
  assign lit      = phase;

endmodule

`default_nettype wire

[rtl/core/button_press_classifier_led_blinker_unit.sv]
// Button press classifier and LED blinker. Each input transaction is one tick
// carrying the raw button level; it produces exactly one result transaction
// with the button state, LED mode and LED drive after that tick. The press
// machine and blinker registers double as the result register, so a result
// appears in the cycle after its input is accepted, and a new input is taken in
// every cycle in which the previous result is taken or none is pending: one
// item per cycle sustained, limited only by the downstream ready. Config writes
// are always ready and should only be issued while no transaction is in flight.
`default_nettype none

module button_press_classifier_led_blinker_unit #(
  parameter int unsigned TIMER_WIDTH = bplb_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bplb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [bplb_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 button_level,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic      [2:0]                           button_state,
  output logic      [2:0]                           led_mode,
  output logic                                      led_lit
);

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic [bplb_pkg::CFG_WIDTH-1:0] debounce_ticks;
  logic [bplb_pkg::CFG_WIDTH-1:0] long_press_ticks;
  logic [bplb_pkg::CFG_WIDTH-1:0] blink_base_ticks;
  logic [TIMER_WIDTH-1:0]         debounce_max;
  logic [TIMER_WIDTH-1:0]         long_max;
  logic [TIMER_WIDTH-1:0]         base_max;
  logic [2:0]                     press_next;
  logic                           step;

  // thresholds above the timer range saturate
  function automatic logic [TIMER_WIDTH-1:0] clamp_cfg(input logic [bplb_pkg::CFG_WIDTH-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > TIMER_MAX) ? TIMER_WIDTH'(TIMER_MAX) : TIMER_WIDTH'(w);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bplb_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bplb_pkg::LONG_PRESS_RESET;
      blink_base_ticks <= bplb_pkg::BLINK_BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bplb_pkg::REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        bplb_pkg::REG_LONG_PRESS: long_press_ticks <= cfg_data;
        bplb_pkg::REG_BLINK_BASE: blink_base_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign debounce_max = clamp_cfg(debounce_ticks);
  assign long_max     = clamp_cfg(long_press_ticks);
  assign base_max     = clamp_cfg(blink_base_ticks);

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  bplb_press #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_press (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .level       (button_level),
    .debounce_max(debounce_max),
    .long_max    (long_max),
    .state_now   (button_state),
    .state_next  (press_next)
  );

  bplb_blink #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_blink (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .press_next(press_next),
    .base_max  (base_max),
    .mode_now  (led_mode),
    .lit       (led_lit)
  );

`include "assert_macros.svh"

  `BPLB_ASSERT(a_off_is_dark, led_mode == bplb_pkg::LED_OFF |-> !led_lit)
  `BPLB_ASSERT(a_state_only_on_accept, !(in_valid && in_ready) |=> $stable(button_state))
  `BPLB_ASSERT(a_released_to_idle, in_valid && in_ready && button_state == bplb_pkg::ST_RELEASED |=> button_state == bplb_pkg::ST_IDLE)
  `BPLB_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready)

endmodule

`default_nettype wire

[bench/press_led_checker.sv]
`timescale 1ns / 100ps
// checker: predicts button state, led mode and led drive for every tick and compares results
module press_led_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  input  wire logic                                 cfg_ready,
  input  wire logic [bplb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [bplb_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic                                 button_level,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [2:0]                           button_state,
  input  wire logic [2:0]                           led_mode,
  input  wire logic                                 led_lit,
  output int unsigned                               mismatches,
  output int unsigned                               outstanding
);

  typedef struct packed {
    logic [2:0] state;
    logic [2:0] mode;
    logic       lit;
  } tick_outcome_t;

  logic [bplb_pkg::CFG_WIDTH-1:0]           debounce_lim;
  logic [bplb_pkg::CFG_WIDTH-1:0]           long_lim;
  logic [bplb_pkg::CFG_WIDTH-1:0]           blink_base;
  logic [2:0]                               press_st;
  logic [bplb_pkg::TIMER_WIDTH_DEFAULT-1:0] press_cnt;
  logic [2:0]                               blink_sel;
  logic [bplb_pkg::TIMER_WIDTH_DEFAULT-1:0] blink_cnt;
  logic                                     blink_on;
  tick_outcome_t                            tick_outcomes[$];

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // press machine first, then the mode reacts to the new state, then the blinker
  task automatic classify_tick(input logic level, output tick_outcome_t res);
    logic [bplb_pkg::TIMER_WIDTH_DEFAULT-1:0] half;
    case (press_st)
      bplb_pkg::ST_DEBOUNCING: begin
        // level is ignored while debouncing
        press_cnt = press_cnt + 1'b1;
        if (press_cnt >= debounce_lim) begin
          press_st = bplb_pkg::ST_PRESSED;
          press_cnt = '0;
        end
      end
      bplb_pkg::ST_PRESSED, bplb_pkg::ST_DOWN: begin
        if (!level) begin
          press_st = (press_st == bplb_pkg::ST_PRESSED) ? bplb_pkg::ST_RELEASED
                                                        : bplb_pkg::ST_IDLE;
        end else if (press_cnt >= long_lim) begin
          press_st = bplb_pkg::ST_HELD;
        end else begin
          press_cnt = press_cnt + 1'b1;
        end
      end
      bplb_pkg::ST_HELD: begin
        if (!level) begin
          press_st = bplb_pkg::ST_IDLE;
        end else begin
          press_st = bplb_pkg::ST_DOWN;
          press_cnt = '0;
        end
      end
      bplb_pkg::ST_RELEASED: begin
        press_st = bplb_pkg::ST_IDLE;
      end
      default: begin
        if (level) begin
          press_st = bplb_pkg::ST_DEBOUNCING;
          press_cnt = '0;
        end else begin
          press_st = bplb_pkg::ST_IDLE;
        end
      end
    endcase

    if (press_st == bplb_pkg::ST_HELD) begin
      blink_sel = (blink_sel == bplb_pkg::LED_OFF) ? bplb_pkg::LED_MODE_FIRST
                                                   : bplb_pkg::LED_OFF;
    end else if (press_st == bplb_pkg::ST_RELEASED && blink_sel != bplb_pkg::LED_OFF) begin
      blink_sel = (blink_sel >= bplb_pkg::LED_MODE_LAST) ? bplb_pkg::LED_MODE_FIRST
                                                         : blink_sel + 3'd1;
    end

    // led off keeps the blink timer and forces a dark phase
    if (blink_sel == bplb_pkg::LED_OFF || blink_sel > bplb_pkg::LED_MODE_LAST) begin
      blink_sel = bplb_pkg::LED_OFF;
      blink_on = 1'b0;
    end else begin
      half = blink_base >> (blink_sel - bplb_pkg::LED_MODE_FIRST);
      blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt >= half) begin
        blink_on = ~blink_on;
        blink_cnt = '0;
      end
    end

    res.state = press_st;
    res.mode = blink_sel;
    res.lit = blink_on;
  endtask

  always @(posedge clk) begin : watch
    tick_outcome_t want;
    tick_outcome_t fresh;
    if (rst) begin
      debounce_lim = bplb_pkg::DEBOUNCE_RESET;
      long_lim = bplb_pkg::LONG_PRESS_RESET;
      blink_base = bplb_pkg::BLINK_BASE_RESET;
      press_st = bplb_pkg::ST_IDLE;
      press_cnt = '0;
      blink_sel = bplb_pkg::LED_OFF;
      blink_cnt = '0;
      blink_on = 1'b0;
      tick_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bplb_pkg::REG_DEBOUNCE:   debounce_lim = cfg_data;
          bplb_pkg::REG_LONG_PRESS: long_lim = cfg_data;
          bplb_pkg::REG_BLINK_BASE: blink_base = cfg_data;
          default: ;
        endcase
      end
      // result of an earlier tick is checked before this edge's tick is predicted
      if (out_valid && out_ready) begin
        if (tick_outcomes.size() == 0) begin
          report($sformatf("result transaction with nothing pending (state %0d mode %0d lit %0d)",
                           button_state, led_mode, led_lit));
        end else begin
          want = tick_outcomes.pop_front();
          if (button_state !== want.state)
            report($sformatf("button_state got %0d, expected %0d", button_state, want.state));
          if (led_mode !== want.mode)
            report($sformatf("led_mode got %0d, expected %0d", led_mode, want.mode));
          if (led_lit !== want.lit)
            report($sformatf("led_lit got %0d, expected %0d", led_lit, want.lit));
        end
      end
      if (in_valid && in_ready) begin
        classify_tick(button_level, fresh);
        tick_outcomes.push_back(fresh);
      end
    end
    outstanding <= tick_outcomes.size();
  end

endmodule

[bench/tb_button_press_classifier_led_blinker_unit.sv]
`timescale 1ns / 100ps
// testbench top: drives button ticks and register writes into the classifier and gives the verdict
module tb_button_press_classifier_led_blinker_unit;

  // index with no register behind it
  localparam logic [bplb_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;
  localparam logic [7:0]  RESET_CFG_LEVELS = 8'b0111_1110;
  localparam logic [15:0] OPENING_LEVELS   = 16'b1011_1111_0101_0011;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_valid = 1'b0;
  logic [bplb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [bplb_pkg::CFG_WIDTH-1:0]       cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 button_level = 1'b0;
  logic                                 out_ready = 1'b0;
  wire                                  cfg_ready;
  wire                                  in_ready;
  wire                                  out_valid;
  wire  [2:0]                           button_state;
  wire  [2:0]                           led_mode;
  wire                                  led_lit;
  int unsigned                          mismatches;
  int unsigned                          outstanding;

  int                                   tx_idle_pct = 30;
  int                                   rx_idle_pct = 78;
  int unsigned                          ticks_sent = 0;
  logic [bplb_pkg::CFG_WIDTH-1:0]       db_now = bplb_pkg::DEBOUNCE_RESET;
  logic [bplb_pkg::CFG_WIDTH-1:0]       lp_now = bplb_pkg::LONG_PRESS_RESET;

  always #5 clk = ~clk;

  button_press_classifier_led_blinker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_state (button_state),
    .led_mode     (led_mode),
    .led_lit      (led_lit)
  );

  press_led_checker chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_state (button_state),
    .led_mode     (led_mode),
    .led_lit      (led_lit),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // valid stays high from one tick to the next unless an idle cycle is drawn
  task automatic send_tick(input logic level);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    button_level <= level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned count);
    repeat (count) send_tick(level);
  endtask

  // hold off until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(input logic [bplb_pkg::CFG_INDEX_WIDTH-1:0] idx,
                         input logic [bplb_pkg::CFG_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_timing(input logic [bplb_pkg::CFG_WIDTH-1:0] db,
                            input logic [bplb_pkg::CFG_WIDTH-1:0] lp,
                            input logic [bplb_pkg::CFG_WIDTH-1:0] bb);
    drain();
    put_reg(bplb_pkg::REG_DEBOUNCE, db);
    put_reg(bplb_pkg::REG_LONG_PRESS, lp);
    put_reg(bplb_pkg::REG_BLINK_BASE, bb);
    cfg_valid <= 1'b0;
    @(posedge clk);
    db_now = db;
    lp_now = lp;
  endtask

  // clean press, long enough to clear a debounce limit of up to 8, held for a random span, then a short release
  task automatic press_and_release();
    int unsigned hold;
    hold = ((db_now > 8) ? 8 : db_now) + 1 +
           $urandom_range(2 * ((lp_now > 12) ? 12 : lp_now) + 3);
    send_run(1'b1, hold);
    send_run(1'b0, $urandom_range(4, 1));
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned goal;
    int          pick;
    goal = ticks_sent + count;
    while (ticks_sent < goal) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        press_and_release();
      end else if (pick < 9) begin
        repeat ($urandom_range(6, 1)) send_tick(1'($urandom_range(1)));
      end else begin
        // bounce: a short press with a dropout
        send_run(1'b1, $urandom_range(3, 1));
        send_tick(1'b0);
        send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 7; i >= 0; i--) send_tick(RESET_CFG_LEVELS[i]);
    set_timing(16'd2, 16'd1, 16'd0);
    for (int i = 15; i >= 0; i--) send_tick(OPENING_LEVELS[i]);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 30;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0: set_timing(16'd1, 16'd3, 16'd4);
        1: set_timing(16'd0, 16'd0, 16'd0);
        3: set_timing(16'd3, 16'd6, 16'hffff);
        5: set_timing(16'hffff, 16'd5, 16'd2);
        6: set_timing(16'd2, 16'hffff, 16'd3);
        8: begin
          drain();
          put_reg(REG_SPARE, 16'ha5a5);
          cfg_valid <= 1'b0;
          @(posedge clk);
          set_timing(16'd1, 16'd2, 16'd16);
        end
        default: set_timing(16'($urandom_range(4, 1)), 16'($urandom_range(12, 1)),
                            16'($urandom_range(40, 1)));
      endcase
      run_phase((ph == 5) ? 30 : 105);
      if (ph == 2) begin
        drain();
        run_phase(50);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
